// ===== design/plint_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plint_pkg
// shared types and constants of the piecewise linear interpolator
// ----------------------------------------------------------------------------
package plint_pkg;

  // request codes
  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  // configuration register indexes
  localparam int  CFG_IDX_W  = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_TABLE_LEN = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ABOVE_VAL = 1'd1;

  localparam int LEN_W   = 7;
  localparam int DATA_W  = 32;
  localparam int DIFF_W  = DATA_W + 1;
  localparam int PROD_W  = 2 * DIFF_W;
  localparam int ENTRY_W = 6;

  typedef enum logic [1:0] {
    REG_BELOW  = 2'd0,
    REG_INTERP = 2'd1,
    REG_ABOVE  = 2'd2
  } region_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WALK,
    ST_MUL,
    ST_LAUNCH,
    ST_DIV,
    ST_DONE
  } state_e;

  // query token that travels down the chain of cells
  typedef struct packed {
    logic                     valid;
    logic                     done;
    region_e                  region;
    logic signed [DATA_W-1:0] xq;
    logic signed [DATA_W-1:0] px;
    logic signed [DATA_W-1:0] py;
    logic signed [DATA_W-1:0] y0;
    logic signed [DIFF_W-1:0] dy;
    logic        [DIFF_W-1:0] dxq;
    logic        [DIFF_W-1:0] dx;
  } tok_t;

endpackage

// ===== design/plint_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plint_cell
// one breakpoint cell: holds x and y, checks the passing query token
// ----------------------------------------------------------------------------
module plint_cell import plint_pkg::*; #(
  parameter int IDX = 0,
  parameter int CW  = 7
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     wr_en_i,
  input  logic        [ENTRY_W-1:0] wr_idx_i,
  input  logic signed [DATA_W-1:0] wr_x_i,
  input  logic signed [DATA_W-1:0] wr_y_i,
  input  logic        [CW-1:0]     n_i,
  input  tok_t                     tok_i,
  output tok_t                     tok_o
);

  logic signed [DATA_W-1:0] ent_x_q, ent_y_q;
  tok_t tok_d, tok_q;
  logic in_use;

  // entry storage, written by a matching load
  always_ff @(posedge clk_i) begin
    if (wr_en_i && (32'(wr_idx_i) == 32'(IDX))) begin
      ent_x_q <= wr_x_i;
      ent_y_q <= wr_y_i;
    end
  end

  assign in_use = (CW'(IDX) < n_i);

  // compare and capture the bracketing segment
  always_comb begin
    tok_d = tok_i;
    if (tok_i.valid && !tok_i.done) begin
      if (IDX == 0) begin
        if (tok_i.xq <= ent_x_q) begin
          tok_d.done   = 1'b1;
          tok_d.region = REG_BELOW;
          tok_d.y0     = ent_y_q;
        end
      end else if (in_use && (ent_x_q > tok_i.xq)) begin
        tok_d.done   = 1'b1;
        tok_d.region = REG_INTERP;
        tok_d.y0     = tok_i.py;
        tok_d.dy     = DIFF_W'(ent_y_q) - DIFF_W'(tok_i.py);
        tok_d.dxq    = DIFF_W'(tok_i.xq) - DIFF_W'(tok_i.px);
        tok_d.dx     = DIFF_W'(ent_x_q) - DIFF_W'(tok_i.px);
      end
    end
    tok_d.px = ent_x_q;
    tok_d.py = ent_y_q;
  end

  // token stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
    end else begin
      tok_q <= tok_d;
    end
  end

  assign tok_o = tok_q;

endmodule

// ===== design/plint_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plint_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module plint_div import plint_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [PROD_W-1:0] dividend_i,
  input  logic [DIFF_W-1:0] divisor_i,
  output logic              busy_o,
  output logic              done_o,
  output logic [PROD_W-1:0] quotient_o
);

  localparam int CNT_W = $clog2(PROD_W + 1);

  logic [DIFF_W-1:0] rem_q, rem_d, dvs_q;
  logic [PROD_W-1:0] quo_q, quo_d;
  logic [CNT_W-1:0]  cnt_q;
  logic              busy_q, done_q;
  logic [DIFF_W:0]   trial;
  logic [DIFF_W:0]   shifted;

  // one subtract and compare step
  always_comb begin
    shifted = {rem_q, quo_q[PROD_W-1]};
    trial   = shifted - {1'b0, dvs_q};
    if (!trial[DIFF_W]) begin
      rem_d = trial[DIFF_W-1:0];
      quo_d = {quo_q[PROD_W-2:0], 1'b1};
    end else begin
      rem_d = shifted[DIFF_W-1:0];
      quo_d = {quo_q[PROD_W-2:0], 1'b0};
    end
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(PROD_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign busy_o     = busy_q;
  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

// ===== design/piecewise_linear_interpolator_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// piecewise_linear_interpolator_top
// breakpoint table in a chain of cells, linear interpolation between them
// ----------------------------------------------------------------------------
//  channel  | direction | handshake           | payload
//  in       | input     | in_valid/in_ready   | req_type, entry_index, x, y
//  out      | output    | out_valid/out_ready | y_result, region
//  cfg      | input     | cfg_we              | cfg_idx, cfg_wdata
//
//  a load beat gives no result
//  a query token walks the chain of cells to the tail cell; a clamped result
//  then passes the done state into the output register
//  an interpolated query first passes the multiply, launch and divide states,
//  then the done state, before its result reaches the output register
//  one item at a time; a new beat is taken while a result waits in the output
//  register; reset clears control only, table entries are unknown until loaded
// ----------------------------------------------------------------------------
module piecewise_linear_interpolator_top import plint_pkg::*; #(
  parameter int TABLE_DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic                     req_type_i,
  input  logic        [ENTRY_W-1:0] entry_index_i,
  input  logic signed [DATA_W-1:0] x_value_i,
  input  logic signed [DATA_W-1:0] y_value_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic signed [DATA_W-1:0] y_result_o,
  output logic        [1:0]        region_o,
  input  logic                     cfg_we_i,
  input  logic [CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic        [DATA_W-1:0] cfg_wdata_i
);

  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int LW = (CW > LEN_W) ? CW : LEN_W;

  state_e state_q, state_d;
  logic [LEN_W-1:0]         len_q;
  logic signed [DATA_W-1:0] above_q;
  logic [LW-1:0]            len_ext;
  logic [CW-1:0]            n_eff;
  logic                     in_acc, load_acc, query_acc;
  tok_t                     tok_w [TABLE_DEPTH+1];
  tok_t                     tok_in, tail, hit_q;
  logic [DIFF_W-1:0]        ady;
  logic [PROD_W-1:0]        prod_q, quo;
  logic                     div_start, div_busy, div_done;
  logic signed [DATA_W+1:0] interp;
  logic signed [DATA_W-1:0] res_y_q;
  region_e                  res_reg_q;
  logic                     out_valid_q, out_free;
  logic signed [DATA_W-1:0] out_y_q;
  region_e                  out_reg_q;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q   <= LEN_W'(2);
      above_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_TABLE_LEN: len_q   <= cfg_wdata_i[LEN_W-1:0];
        CFG_ABOVE_VAL: above_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // breakpoints in use, clamped to one .. depth
  assign len_ext = LW'(len_q);
  always_comb begin
    if (len_q == '0) begin
      n_eff = CW'(1);
    end else if (len_ext > LW'(TABLE_DEPTH)) begin
      n_eff = CW'(TABLE_DEPTH);
    end else begin
      n_eff = len_ext[CW-1:0];
    end
  end

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign load_acc   = in_acc && (req_type_i == REQ_LOAD);
  assign query_acc  = in_acc && (req_type_i == REQ_QUERY);

  // token launched into the head cell
  always_comb begin
    tok_in       = '0;
    tok_in.valid = query_acc;
    tok_in.xq    = x_value_i;
  end
  assign tok_w[0] = tok_in;

  // chain of breakpoint cells
  for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
    plint_cell #(.IDX(g), .CW(CW)) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .wr_en_i  (load_acc),
      .wr_idx_i (entry_index_i),
      .wr_x_i   (x_value_i),
      .wr_y_i   (y_value_i),
      .n_i      (n_eff),
      .tok_i    (tok_w[g]),
      .tok_o    (tok_w[g+1])
    );
  end
  assign tail = tok_w[TABLE_DEPTH];

  // divider for (|dy| * dxq) / dx
  assign ady = hit_q.dy[DIFF_W-1] ? (~hit_q.dy + 1'b1) : hit_q.dy;

  plint_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (prod_q),
    .divisor_i  (hit_q.dx),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .quotient_o (quo)
  );

  assign interp = hit_q.dy[DIFF_W-1]
                ? ((DATA_W+2)'(hit_q.y0) - (DATA_W+2)'({1'b0, quo[DIFF_W-1:0]}))
                : ((DATA_W+2)'(hit_q.y0) + (DATA_W+2)'({1'b0, quo[DIFF_W-1:0]}));

  assign out_free = !out_valid_q || out_ready_i;

  // next state
  always_comb begin
    state_d   = state_q;
    div_start = 1'b0;
    case (state_q)
      ST_IDLE:   if (query_acc) state_d = ST_WALK;
      ST_WALK: begin
        if (tail.valid) begin
          if (tail.done && (tail.region == REG_INTERP)) state_d = ST_MUL;
          else                                          state_d = ST_DONE;
        end
      end
      ST_MUL:    state_d = ST_LAUNCH;
      ST_LAUNCH: begin
        div_start = 1'b1;
        state_d   = ST_DIV;
      end
      ST_DIV:    if (div_done) state_d = ST_DONE;
      ST_DONE:   if (out_free) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // result datapath
  always_ff @(posedge clk_i) begin
    if (state_q == ST_WALK && tail.valid) begin
      hit_q <= tail;
      if (tail.done) begin
        res_y_q   <= tail.y0;
        res_reg_q <= tail.region;
      end else begin
        res_y_q   <= above_q;
        res_reg_q <= REG_ABOVE;
      end
    end
    if (state_q == ST_MUL) begin
      prod_q <= ady * hit_q.dxq;
    end
    if (state_q == ST_DIV && div_done) begin
      res_y_q <= interp[DATA_W-1:0];
    end
    if (state_q == ST_DONE && out_free) begin
      out_y_q   <= res_y_q;
      out_reg_q <= res_reg_q;
    end
  end

  // output beat register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == ST_DONE && out_free) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign y_result_o  = out_y_q;
  assign region_o    = out_reg_q;

  // checks
  a_tail_in_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tail.valid |-> state_q == ST_WALK)
    else $error("token left the chain outside the walk");

  a_div_in_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_busy |-> state_q == ST_DIV)
    else $error("divider busy outside the divide state");

  a_div_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == ST_DIV)
    else $error("divider finished outside the divide state");

  a_region_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_reg_q == REG_BELOW || out_reg_q == REG_INTERP ||
                     out_reg_q == REG_ABOVE))
    else $error("result beat carries an unused region code");

  a_one_token: assert property (@(posedge clk_i) disable iff (!rst_ni)
    query_acc |=> state_q == ST_WALK)
    else $error("query beat did not start a walk");

endmodule

// ===== test/piecewise_linear_interpolator_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// piecewise_linear_interpolator_top_tb
// loads breakpoint tables, fires queries and checks each answer against a
// local interpolation predictor, under several sender and receiver idle modes
// ----------------------------------------------------------------------------
module piecewise_linear_interpolator_top_tb;
  import plint_pkg::*;

  localparam int DEPTH = 64;
  localparam int SETTLE_CYCLES = 200;
  localparam int WATCHDOG_LIMIT = 20000;

  typedef struct {
    logic                     req;
    logic [ENTRY_W-1:0]       idx;
    logic signed [DATA_W-1:0] x;
    logic signed [DATA_W-1:0] y;
  } beat_t;

  typedef struct {
    logic signed [DATA_W-1:0] y;
    region_e                  region;
  } answer_t;

  logic                     clk_i;
  logic                     rst_ni;
  logic                     in_valid_i;
  logic                     in_ready_o;
  logic                     req_type_i;
  logic [ENTRY_W-1:0]       entry_index_i;
  logic signed [DATA_W-1:0] x_value_i;
  logic signed [DATA_W-1:0] y_value_i;
  logic                     out_valid_o;
  logic                     out_ready_i;
  logic signed [DATA_W-1:0] y_result_o;
  logic [1:0]               region_o;
  logic                     cfg_we_i;
  logic [CFG_IDX_W-1:0]     cfg_idx_i;
  logic [DATA_W-1:0]        cfg_wdata_i;

  piecewise_linear_interpolator_top #(.TABLE_DEPTH(DEPTH)) dut (.*);

  // predictor state
  logic signed [DATA_W-1:0] pred_x [DEPTH];
  logic signed [DATA_W-1:0] pred_y [DEPTH];
  logic [LEN_W-1:0]         pred_len;
  logic signed [DATA_W-1:0] pred_above;

  // shadow of the table as the generator has queued it
  logic signed [DATA_W-1:0] gen_x [DEPTH];
  int                       gen_len;

  beat_t   pending_beats[$];
  answer_t expected_answers[$];
  int      fail_count;
  int      send_idle_pct;
  int      recv_stall_pct;
  int      idle_cycles;
  logic    in_taken;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // interpolation between breakpoints, clamped below and above, product before quotient, truncated
  function automatic answer_t interpolate(logic signed [DATA_W-1:0] xq);
    answer_t a;
    int n;
    longint x0, x1, y0, y1, dy, r;
    logic [64:0] ady, dxq, dx, q;
    n = (pred_len == 0) ? 1 : (pred_len > DEPTH) ? DEPTH : int'(pred_len);
    if (xq <= pred_x[0]) begin
      a.y = pred_y[0];
      a.region = REG_BELOW;
      return a;
    end
    for (int i = 1; i < n; i++) begin
      if (pred_x[i] > xq) begin
        x0 = pred_x[i-1];
        x1 = pred_x[i];
        y0 = pred_y[i-1];
        y1 = pred_y[i];
        dy = y1 - y0;
        ady = (dy < 0) ? 65'(-dy) : 65'(dy);
        dxq = 65'(longint'(xq) - x0);
        dx = 65'(x1 - x0);
        q = (ady * dxq) / dx;
        r = (dy < 0) ? y0 - longint'(q) : y0 + longint'(q);
        a.y = r[31:0];
        a.region = REG_INTERP;
        return a;
      end
    end
    a.y = pred_above;
    a.region = REG_ABOVE;
    return a;
  endfunction

  // input driver
  always @(negedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
      if (!in_valid_i || in_taken) begin
        if (pending_beats.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid_i <= 1'b1;
          req_type_i <= pending_beats[0].req;
          entry_index_i <= pending_beats[0].idx;
          x_value_i <= pending_beats[0].x;
          y_value_i <= pending_beats[0].y;
          void'(pending_beats.pop_front());
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // monitor: predict on input beats, check output beats
  always @(posedge clk_i or negedge rst_ni) begin
    answer_t got;
    answer_t want;
    if (!rst_ni) begin
      in_taken <= 1'b0;
      idle_cycles <= 0;
    end else begin
      in_taken <= in_valid_i && in_ready_o;
      if (in_valid_i && in_ready_o) begin
        if (req_type_i == REQ_LOAD) begin
          pred_x[entry_index_i] = x_value_i;
          pred_y[entry_index_i] = y_value_i;
        end else begin
          expected_answers = {expected_answers, interpolate(x_value_i)};
        end
      end
      if (out_valid_o && out_ready_i) begin
        got.y = y_result_o;
        got.region = region_e'(region_o);
        if (expected_answers.size() == 0) begin
          $error("unexpected result y_result=%0d region=%0d", got.y, got.region);
          fail_count++;
        end else begin
          want = expected_answers.pop_front();
          if (got.y !== want.y) begin
            $error("y_result expected %0d actual %0d", want.y, got.y);
            fail_count++;
          end
          if (got.region !== want.region) begin
            $error("region expected %0d actual %0d", want.region, got.region);
            fail_count++;
          end
        end
      end
      // watchdog on beats of either channel
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  task automatic push_load(int idx, logic signed [DATA_W-1:0] x,
                           logic signed [DATA_W-1:0] y);
    beat_t b;
    b.req = REQ_LOAD;
    b.idx = idx[ENTRY_W-1:0];
    b.x = x;
    b.y = y;
    pending_beats = {pending_beats, b};
    gen_x[idx] = x;
  endtask

  task automatic push_query(logic signed [DATA_W-1:0] x);
    beat_t b;
    b.req = REQ_QUERY;
    b.idx = ENTRY_W'($urandom);
    b.x = x;
    b.y = $urandom;
    pending_beats = {pending_beats, b};
  endtask

  // load entries 0..n-1: rising wide, rising narrow, or unordered
  task automatic load_table(int n, int shape);
    longint xs[$];
    longint v;
    v = -longint'($urandom_range(200000));
    for (int i = 0; i < n; i++) begin
      if (shape == 0) xs = {xs, longint'(int'($urandom))};
      else if (shape == 1) begin
        v += $urandom_range(1, 3000);
        xs = {xs, v};
      end else xs = {xs, longint'(int'($urandom)) >>> $urandom_range(16)};
    end
    if (shape == 0) begin
      xs.sort();
      for (int i = 1; i < n; i++) if (xs[i] <= xs[i-1]) xs[i] = xs[i-1] + 1;
    end
    for (int i = 0; i < n; i++) begin
      push_load(i, xs[i][31:0], (i % 9 == 4) ? 32'h7fffffff :
                (i % 9 == 5) ? 32'h80000000 : $urandom);
    end
  endtask

  // queries near breakpoints, between them, anywhere, or at the extremes
  task automatic fire_queries(int count);
    int k;
    longint lo, hi;
    for (int i = 0; i < count; i++) begin
      k = $urandom_range(gen_len - 1);
      case ($urandom_range(3))
        0: push_query(gen_x[k] + $urandom_range(2) - 1);
        1: begin
          lo = gen_x[k];
          hi = (k + 1 < gen_len) ? longint'(gen_x[k+1]) : lo + 100;
          if (hi <= lo) hi = lo + 1;
          push_query(DATA_W'(lo + longint'($urandom) % (hi - lo)));
        end
        2: push_query($urandom);
        default: push_query(($urandom_range(1)) ? 32'h7fffffff : 32'h80000000);
      endcase
    end
  endtask

  task automatic drain();
    while (pending_beats.size() > 0 || in_valid_i || expected_answers.size() > 0) begin
      @(posedge clk_i);
      #1;
    end
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= data;
    if (idx == CFG_TABLE_LEN) pred_len = data[LEN_W-1:0];
    else pred_above = data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_config(int len, logic [DATA_W-1:0] above);
    write_reg(CFG_TABLE_LEN, len);
    write_reg(CFG_ABOVE_VAL, above);
    gen_len = (len == 0) ? 1 : (len > DEPTH) ? DEPTH : len;
  endtask

  // stimulus
  initial begin
    int lens[6];
    fail_count = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    pred_len = 2;
    pred_above = '0;
    gen_len = 2;
    in_valid_i = 1'b0;
    out_ready_i = 1'b0;
    req_type_i = REQ_LOAD;
    entry_index_i = '0;
    x_value_i = '0;
    y_value_i = '0;
    cfg_we_i = 1'b0;
    cfg_idx_i = CFG_TABLE_LEN;
    cfg_wdata_i = '0;
    rst_ni = 1'b0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // whole table first so no query ever reads an unloaded entry
    load_table(DEPTH, 0);
    push_load(0, 32'h80000000, 32'h7fffffff);
    drain();
    set_config(DEPTH, 32'h7fffffff);
    push_query(32'h80000000);
    push_query(32'h80000001);
    push_query(32'h7fffffff);
    push_query(gen_x[DEPTH-1]);
    push_query(gen_x[DEPTH-1] - 1);
    push_query(gen_x[10]);
    push_query(gen_x[10] + 1);
    drain();
    set_config(0, 32'h80000000);
    push_query(32'h7fffffff);
    push_query(32'h80000000);
    drain();
    set_config(127, 32'h0);
    push_query(32'h7fffffff);
    push_query(gen_x[DEPTH-1] - 1);
    // unordered table
    load_table(8, 2);
    push_query($urandom);
    push_query($urandom);
    // sender holds off until every answer is back
    drain();

    lens = '{1, 2, 64, 0, 127, 5};
    for (int phase = 0; phase < 12; phase++) begin
      case (phase % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 57; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 57; end
        default: begin send_idle_pct = 6; recv_stall_pct = 6; end
      endcase
      set_config((phase < 6) ? lens[phase] : $urandom_range(1, 16),
                 (phase % 3 == 0) ? $urandom : (phase % 3 == 1) ? 32'h80000000 :
                 32'h7fffffff);
      for (int round = 0; round < 2; round++) begin
        load_table(gen_len, ($urandom_range(9) == 0) ? 2 : $urandom_range(1));
        fire_queries(15);
        // stray reloads of entries beyond the active length
        if (gen_len < DEPTH) push_load($urandom_range(gen_len, DEPTH - 1),
                                       $urandom, $urandom);
      end
      drain();
    end

    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/plint_pkg.sv
design/plint_cell.sv
design/plint_div.sv
design/piecewise_linear_interpolator_top.sv
test/piecewise_linear_interpolator_top_tb.sv
